[rtl/tdq_pkg.sv]
// Package for the timer deadline queue: operation and result codes, field widths,
// sequencer states and the types shared by the queue's modules. No dependencies.
`default_nettype none
package tdq_pkg;
    localparam int IdW  = 32;
    localparam int DlW  = 48;
    localparam int PerW = 32;
    localparam int OrdW = 32;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_FIRE   = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    localparam int MaxOut = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]     op;
        logic [IdW-1:0] delay_ms;
        logic [IdW-1:0] period_ms;
        logic [IdW-1:0] cancel_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]     kind;
        logic [IdW-1:0] timer_id;
        logic           status;
        logic           last;
    } out_item_t;
endpackage
`default_nettype wire

[rtl/tdq_if.sv]
// Valid/ready channel interface carrying one beat of a payload type.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface tdq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/timer_deadline_queue_top.sv]
// Top level of the timer deadline queue: slot table, sequencer and output register.
// Depends on tdq_pkg, tdq_if and tdq_cmp.
`default_nettype none
// One item is taken at a time. An add or cancel scans the slots one per cycle, then
// acts on the slot found and loads its result beat; a tick repeats a scan, an act and
// an emit per fired timer and ends with one final scan. Each result beat waits for the
// sink to take the last one. The shared compare unit is visited once per slot in every scan.
module timer_deadline_queue_top
    import tdq_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    tdq_if.sink       in_ch,
    tdq_if.source     out_ch
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(MaxOut + 1);

    logic [SLOTS-1:0] valid_reg;
    logic [IdW-1:0]   id_mem  [SLOTS];
    logic [DlW-1:0]   dl_mem  [SLOTS];
    logic [PerW-1:0]  per_mem [SLOTS];
    logic [OrdW-1:0]  ord_mem [SLOTS];

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [DlW-1:0]  clock_reg;
    logic [IdW-1:0]  next_id_reg;
    logic [OrdW-1:0] ins_reg;
    logic [CW-1:0]   idx_reg;
    logic            found_reg;
    logic [SW-1:0]   best_reg;
    logic [NW-1:0]   nout_reg;
    logic [IdW-1:0]  fire_id_reg;
    out_item_t       out_reg;
    logic            out_valid_reg;

    logic [SW-1:0] idx;
    logic          cand_ok;
    logic          earlier;
    logic          scan_done;
    logic          out_load;
    out_item_t     out_next;

    assign idx = idx_reg[SW-1:0];
    assign scan_done = (idx_reg == CW'(SLOTS - 1));

    tdq_cmp u_cmp (
        .cand_dl  (dl_mem[idx]),
        .cand_ord (ord_mem[idx]),
        .best_dl  (dl_mem[best_reg]),
        .best_ord (ord_mem[best_reg]),
        .earlier  (earlier)
    );

    always_comb
    begin
        case (item_reg.op)
            OP_ADD:    cand_ok = !valid_reg[idx] && !found_reg;
            OP_CANCEL: cand_ok = valid_reg[idx] && (id_mem[idx] == item_reg.cancel_id)
                                 && (!found_reg || earlier);
            default:   cand_ok = valid_reg[idx] && (dl_mem[idx] <= clock_reg)
                                 && (nout_reg != NW'(MaxOut))
                                 && (!found_reg || earlier);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && (in_ch.data.op == OP_TICK || in_ch.data.op == OP_ADD
                                    || in_ch.data.op == OP_CANCEL))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    if (item_reg.op == OP_TICK && !found_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                state_next = ST_IDLE;
                if (item_reg.op == OP_TICK)
                begin
                    state_next = ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // A fired beat is held until the following scan shows whether it is the last one.
    always_comb
    begin
        out_load = 1'b0;
        out_next = out_reg;
        if (state_reg == ST_ACT && (!out_valid_reg || out_ch.ready))
        begin
            case (item_reg.op)
                OP_ADD:
                begin
                    out_load = 1'b1;
                    if (found_reg)
                    begin
                        out_next = '{kind: KIND_ADD, timer_id: next_id_reg,
                                     status: 1'b0, last: 1'b1};
                    end
                    else
                    begin
                        out_next = '{kind: KIND_ADD, timer_id: '0, status: 1'b1, last: 1'b1};
                    end
                end
                OP_CANCEL:
                begin
                    out_load = 1'b1;
                    out_next = '{kind: KIND_CANCEL, timer_id: item_reg.cancel_id,
                                 status: !found_reg, last: 1'b1};
                end
                default:
                begin
                    out_load = (nout_reg != '0);
                    out_next = '{kind: KIND_FIRE, timer_id: fire_id_reg,
                                 status: 1'b0, last: !found_reg};
                end
            endcase
        end
    end

    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            clock_reg     <= '0;
            next_id_reg   <= IdW'(1);
            ins_reg       <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            nout_reg      <= '0;
            fire_id_reg   <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    nout_reg  <= '0;
                    if (in_ch.valid && in_ch.data.op == OP_TICK)
                    begin
                        clock_reg <= clock_reg + DlW'(1);
                    end
                end
                ST_SCAN:
                begin
                    if (cand_ok)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= idx;
                    end
                    idx_reg <= idx_reg + CW'(1);
                end
                ST_ACT:
                begin
                    if ((!out_valid_reg || out_ch.ready) && found_reg)
                    begin
                        case (item_reg.op)
                            OP_ADD:
                            begin
                                valid_reg[best_reg] <= 1'b1;
                                id_mem[best_reg]    <= next_id_reg;
                                dl_mem[best_reg]    <= clock_reg + DlW'((item_reg.delay_ms == '0)
                                                       ? IdW'(1) : item_reg.delay_ms);
                                per_mem[best_reg]   <= item_reg.period_ms;
                                ord_mem[best_reg]   <= ins_reg;
                                ins_reg             <= ins_reg + OrdW'(1);
                                next_id_reg <= (next_id_reg == '1) ? IdW'(1)
                                               : next_id_reg + IdW'(1);
                            end
                            OP_CANCEL:
                            begin
                                valid_reg[best_reg] <= 1'b0;
                            end
                            default:
                            begin
                                if (per_mem[best_reg] != '0)
                                begin
                                    dl_mem[best_reg]  <= clock_reg + DlW'(per_mem[best_reg]);
                                    ord_mem[best_reg] <= ins_reg;
                                    ins_reg           <= ins_reg + OrdW'(1);
                                end
                                else
                                begin
                                    valid_reg[best_reg] <= 1'b0;
                                end
                                nout_reg    <= nout_reg + NW'(1);
                                fire_id_reg <= id_mem[best_reg];
                            end
                        endcase
                    end
                end
                ST_EMIT:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            item_reg <= in_ch.data;
        end
    end

    property p_ready_idle;
        @(posedge clk) disable iff (!rst_n) in_ch.ready |-> state_reg == ST_IDLE;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

    property p_id_nonzero;
        @(posedge clk) disable iff (!rst_n) next_id_reg != '0;
    endproperty
    a_id_nonzero: assert property (p_id_nonzero) else $error("timer id counter is zero");

    property p_nout_bound;
        @(posedge clk) disable iff (!rst_n) nout_reg <= NW'(MaxOut);
    endproperty
    a_nout_bound: assert property (p_nout_bound) else $error("too many fired beats");
endmodule
`default_nettype wire

[rtl/tdq_cmp.sv]
// Shared compare unit: decides whether a candidate slot precedes the best so far.
// Depends on tdq_pkg.
`default_nettype none
module tdq_cmp
    import tdq_pkg::*;
(
    input  wire logic [DlW-1:0]  cand_dl,
    input  wire logic [OrdW-1:0] cand_ord,
    input  wire logic [DlW-1:0]  best_dl,
    input  wire logic [OrdW-1:0] best_ord,
    output logic                 earlier
);
    logic [OrdW-1:0] diff;
    assign diff = cand_ord - best_ord;
    always_comb
    begin
        if (cand_dl != best_dl)
        begin
            earlier = cand_dl < best_dl;
        end
        else
        begin
            earlier = diff[OrdW-1];
        end
    end
endmodule
`default_nettype wire

[tb/sv/tdq_sb.sv]
// Scoreboard for the timer deadline queue: a predictor of the slot table and a store of
// expected result beats. Depends on tdq_pkg.
package tdq_sb_pkg;
    import tdq_pkg::*;

    class tdq_scoreboard;
        bit          live[16];
        bit [31:0]   tid[16];
        bit [47:0]   due_at[16];
        bit [31:0]   every[16];
        bit [31:0]   stamp[16];
        bit [47:0]   now_ms;
        bit [31:0]   id_next;
        bit [31:0]   stamp_next;
        out_item_t   pending[$];
        int          errors;

        function new();
            now_ms = 0;
            id_next = 1;
            stamp_next = 0;
            errors = 0;
            foreach (live[i]) live[i] = 0;
        endfunction

        function bit sooner(int a, int b);
            bit [31:0] d;
            if (due_at[a] != due_at[b]) return due_at[a] < due_at[b];
            d = stamp[a] - stamp[b];
            return d[31];
        endfunction

        function int pick(bit by_due, bit [31:0] id);
            int best;
            best = -1;
            for (int s = 0; s < 16; s++)
            begin
                if (!live[s]) continue;
                if (by_due ? (due_at[s] > now_ms) : (tid[s] != id)) continue;
                if (best < 0 || sooner(s, best)) best = s;
            end
            return best;
        endfunction

        function void push(bit [1:0] k, bit [31:0] id, bit st);
            out_item_t r;
            r.kind = k;
            r.timer_id = id;
            r.status = st;
            r.last = 0;
            pending.push_back(r);
        endfunction

        function int note_input(in_item_t it);
            int n;
            int s;
            n = 0;
            if (it.op == OP_ADD)
            begin
                s = -1;
                for (int i = 0; i < 16; i++)
                    if (!live[i] && s < 0) s = i;
                if (s < 0) push(KIND_ADD, 0, 1);
                else
                begin
                    live[s] = 1;
                    tid[s] = id_next;
                    due_at[s] = now_ms + ((it.delay_ms == 0) ? 48'd1 : 48'(it.delay_ms));
                    every[s] = it.period_ms;
                    stamp[s] = stamp_next;
                    stamp_next = stamp_next + 1;
                    push(KIND_ADD, id_next, 0);
                    id_next++;
                    if (id_next == 0) id_next = 1;
                end
                n = 1;
            end
            else if (it.op == OP_CANCEL)
            begin
                s = pick(0, it.cancel_id);
                if (s >= 0) live[s] = 0;
                push(KIND_CANCEL, it.cancel_id, s < 0);
                n = 1;
            end
            else if (it.op == OP_TICK)
            begin
                now_ms++;
                while (n < MaxOut)
                begin
                    s = pick(1, 0);
                    if (s < 0) break;
                    push(KIND_FIRE, tid[s], 0);
                    n++;
                    if (every[s] != 0)
                    begin
                        due_at[s] = now_ms + 48'(every[s]);
                        stamp[s] = stamp_next;
                        stamp_next = stamp_next + 1;
                    end
                    else live[s] = 0;
                end
            end
            if (n > 0) pending[$].last = 1;
            return n;
        endfunction

        function bit check_result(out_item_t got, output out_item_t want);
            if (pending.size() == 0) return 0;
            want = pending.pop_front();
            return got == want;
        endfunction
    endclass
endpackage

[tb/sv/tb_timer_deadline_queue_top.sv]
// Testbench top for the timer deadline queue: drives timer commands with random gaps,
// stalls the result side, and checks every beat. Depends on tdq_pkg, tdq_if, tdq_sb_pkg.
module tb_timer_deadline_queue_top;
    import tdq_pkg::*;
    import tdq_sb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0;
    logic rst_n = 0;
    tdq_if #(.T(in_item_t))  in_ch ();
    tdq_if #(.T(out_item_t)) out_ch ();
    tdq_scoreboard timers = new();
    int  hold_cycles = 0;
    bit  stim_done = 0;
    int  noted_ids[$];

    timer_deadline_queue_top dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    initial
    begin
        #3000000;
        $display("timer_deadline_queue_top: mismatch");
        $finish;
    end

    task automatic report(string what, out_item_t got, out_item_t want);
        timers.errors++;
        $display("ERROR %s: got kind %0d id %0d st %0d last %0d, want %0d %0d %0d %0d", what,
            got.kind, got.timer_id, got.status, got.last,
            want.kind, want.timer_id, want.status, want.last);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
            if (!timers.check_result(out_ch.data, want))
                report("result", out_ch.data, want);
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            void'(timers.note_input(in_ch.data));
            if (in_ch.data.op == OP_ADD && timers.pending[$].status == 0)
                noted_ids.push_back(timers.pending[$].timer_id);
        end
    end

    initial
    begin
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ch.ready <= 0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0) || stim_done && 0 ||
                    ($urandom_range(0, 1) == 1);
        end
    end

    task automatic send(bit [1:0] op, bit [31:0] dl, bit [31:0] per, bit [31:0] cid);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_ch.valid <= 0;
            repeat (g) @(negedge clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= '{op: op, delay_ms: dl, period_ms: per, cancel_id: cid};
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic ticks(int n);
        for (int i = 0; i < n; i++) send(OP_TICK, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        bit [31:0] pick_id;
        int r;
        int guard;
        in_ch.valid = 0;
        in_ch.data = '0;
        repeat (3) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send(OP_TICK, 0, 0, 0);
        send(OP_ADD, 0, 0, 0);
        send(OP_ADD, 1, 3, 0);
        send(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send(OP_ADD, 2, 0, 0);
        send(OP_ADD, 2, 0, 0);
        send(OP_CANCEL, 0, 0, 4);
        send(OP_CANCEL, 0, 0, 32'hFFFF_FFFF);
        send(OP_UNUSED, 5, 5, 5);
        ticks(4);
        hold_cycles = 200;
        for (int i = 0; i < 14; i++) send(OP_ADD, 1, 1, 0);
        ticks(3);
        for (int i = 0; i < 16; i++) send(OP_CANCEL, 0, 0, 32'(i + 1));
        for (int i = 0; i < 17; i++) send(OP_ADD, 5, 0, 0);
        ticks(6);

        for (int i = 0; i < 280; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send(OP_TICK, $urandom, $urandom, $urandom);
            else if (r < 75)
                send(OP_ADD, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8),
                    ($urandom_range(0, 9) == 0) ? $urandom :
                    ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6)), $urandom);
            else if (r < 97)
            begin
                if (noted_ids.size() > 0 && $urandom_range(0, 3) != 0)
                    pick_id = noted_ids[$urandom_range(0, noted_ids.size() - 1)];
                else
                    pick_id = $urandom;
                send(OP_CANCEL, $urandom, $urandom, pick_id);
            end
            else
                send(OP_UNUSED, $urandom, $urandom, $urandom);
            if (i == 150) hold_cycles = 300;
        end
        in_ch.valid <= 0;

        stim_done = 1;
        guard = 0;
        while (timers.pending.size() > 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (timers.pending.size() == 0 && timers.errors == 0)
            $display("timer_deadline_queue_top: match");
        else
            $display("timer_deadline_queue_top: mismatch");
        $finish;
    end
endmodule

[timer_deadline_queue_top.f]
rtl/tdq_pkg.sv
rtl/tdq_if.sv
rtl/tdq_cmp.sv
rtl/timer_deadline_queue_top.sv
tb/sv/tdq_sb.sv
tb/sv/tb_timer_deadline_queue_top.sv
